// ===== sv/stfs_block_address_mapper_unit_defines.svh =====
// assertion helpers for the block address mapper
`ifndef STFS_BLOCK_ADDRESS_MAPPER_UNIT_DEFINES_SVH
`define STFS_BLOCK_ADDRESS_MAPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define STFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, held off during reset
`define STFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define STFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/stfs_bam_pkg.sv =====
package stfs_bam_pkg;

    // filesystem geometry
    localparam int unsigned TableSpan  = 170;
    localparam int unsigned Level1Span = 28900;
    localparam logic [23:0] BlockLimit = 24'hFFFFFF;

    // step constants per package kind
    localparam logic [7:0]  Step0Single = 8'hAB;
    localparam logic [7:0]  Step0Double = 8'hAC;
    localparam logic [15:0] Step1Single = 16'h718F;
    localparam logic [15:0] Step1Double = 16'h723A;

    // reciprocals for division by constants, scaled by 2^RecipShift
    localparam int unsigned RecipShift = 32;
    localparam logic [24:0] Recip0 = 25'((64'd1 << RecipShift) / TableSpan);
    localparam logic [17:0] Recip1 = 18'((64'd1 << RecipShift) / Level1Span);
    localparam logic [17:0] RecipSkipSingle = 18'((64'd1 << RecipShift) / Step1Single);
    localparam logic [17:0] RecipSkipDouble = 18'((64'd1 << RecipShift) / Step1Double);

    // an index of minus one after the level-1 fold, only reachable with doubled copies
    localparam bit NegOneDivisible = ((32'hFFFFFFFF % 32'(Step1Double)) == 32'd0);

    // skip sizes in units of 4 KiB before the kind scaling
    localparam logic [1:0] SkipOne   = 2'd1;
    localparam logic [1:0] SkipTwo   = 2'd2;
    localparam logic [1:0] SkipThree = 2'd3;

    // configuration register indexes
    localparam int unsigned CfgIndexWidth = 2;
    localparam logic [CfgIndexWidth-1:0] CfgPackageKind       = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CfgFirstTableAddress = 2'd1;

    typedef struct packed {
        logic        package_kind;
        logic [31:0] first_table_address;
    } t_cfg;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

// ===== sv/stfs_block_address_mapper_unit.sv =====
// throughput: one beat per cycle while no stall comes from downstream
// a stall from downstream holds every full stage that has no free stage after it, bubbles are squeezed out
// reset (synchronous, active low) clears stage valid bits and the config registers
// configuration port is always ready and applies a write in the cycle it is taken
`include "stfs_block_address_mapper_unit_defines.svh"

module stfs_block_address_mapper_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [23:0]                            i_block_number,
    input  logic [31:0]                            i_table_address,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [31:0]                            o_data_address,
    output logic [23:0]                            o_level0_table_block,
    output logic [23:0]                            o_level1_table_block,
    output logic [14:0]                            o_skip_bytes,
    output logic                                   o_block_error,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [stfs_bam_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [31:0]                            i_cfg_data
);

    stfs_bam_pkg::t_cfg     w_cfg;
    stfs_bam_pkg::t_pipe_en w_en;
    logic [3:0]             r_vld;

    // configuration registers
    stfs_bam_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // stage enables: a stage loads when empty or when the next one loads
    assign w_en.s4 = !r_vld[3] || !i_stall;
    assign w_en.s3 = !r_vld[2] || w_en.s4;
    assign w_en.s2 = !r_vld[1] || w_en.s3;
    assign w_en.s1 = !r_vld[0] || w_en.s2;

    assign o_stall = !w_en.s1;
    assign o_valid = r_vld[3];

    // valid bits follow the data through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else begin
            if (w_en.s1) begin
                r_vld[0] <= i_valid;
            end
            if (w_en.s2) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_en.s3) begin
                r_vld[2] <= r_vld[1];
            end
            if (w_en.s4) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    // block number to addresses
    stfs_bam_map u_map (
        .i_clk                (i_clk),
        .i_en                 (w_en),
        .i_cfg                (w_cfg),
        .i_block_number       (i_block_number),
        .o_data_address       (o_data_address),
        .o_level0_table_block (o_level0_table_block),
        .o_level1_table_block (o_level1_table_block),
        .o_block_error        (o_block_error)
    );

    // table address to skip size
    stfs_bam_skip u_skip (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_cfg           (w_cfg),
        .i_table_address (i_table_address),
        .o_skip_bytes    (o_skip_bytes)
    );

    // pipeline checks
    `STFS_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_stall, (&r_vld), "upstream stalled with a free stage")
    `STFS_ASSERT_NEXT(a_accept_fills_stage1, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "accepted beat did not reach stage one")
    `STFS_ASSERT_IMPL(a_error_zero_address, i_clk, i_rst_n, o_valid && o_block_error, o_data_address == 32'd0, "error beat carries an address")
    `STFS_ASSERT_IMPL(a_skip_legal, i_clk, i_rst_n, o_valid, o_skip_bytes == 15'h1000 || o_skip_bytes == 15'h2000 || o_skip_bytes == 15'h3000 || o_skip_bytes == 15'h4000 || o_skip_bytes == 15'h6000, "skip size outside the legal set")

endmodule

// ===== sv/stfs_bam_cfg.sv =====
module stfs_bam_cfg (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [stfs_bam_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [31:0]                            i_cfg_data,
    output stfs_bam_pkg::t_cfg                     o_cfg
);

    logic        r_package_kind;
    logic [31:0] r_first_table_address;

    assign o_cfg_ready = 1'b1;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_package_kind        <= 1'b0;
            r_first_table_address <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stfs_bam_pkg::CfgPackageKind: begin
                    r_package_kind <= i_cfg_data[0];
                end
                stfs_bam_pkg::CfgFirstTableAddress: begin
                    r_first_table_address <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.package_kind        = r_package_kind;
    assign o_cfg.first_table_address = r_first_table_address;

endmodule

// ===== sv/stfs_bam_map.sv =====
module stfs_bam_map (
    input  logic                   i_clk,
    input  stfs_bam_pkg::t_pipe_en i_en,
    input  stfs_bam_pkg::t_cfg     i_cfg,
    input  logic [23:0]            i_block_number,
    output logic [31:0]            o_data_address,
    output logic [23:0]            o_level0_table_block,
    output logic [23:0]            o_level1_table_block,
    output logic                   o_block_error
);

    // stage 1: reciprocal estimates of the two quotients
    logic [48:0] w_prod0;
    logic [41:0] w_prod1;
    logic [23:0] r1_b;
    logic [16:0] r1_q0e;
    logic [9:0]  r1_q1e;

    assign w_prod0 = 49'(i_block_number) * 49'(stfs_bam_pkg::Recip0);
    assign w_prod1 = 42'(i_block_number) * 42'(stfs_bam_pkg::Recip1);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_b   <= i_block_number;
            r1_q0e <= w_prod0[48:32];
            r1_q1e <= w_prod1[41:32];
        end
    end

    // stage 2: remainder check, bump estimate by one where short
    logic [24:0] w_rem0;
    logic [23:0] w_rem1;
    logic [23:0] r2_b;
    logic [16:0] r2_q0;
    logic [9:0]  r2_q1;

    assign w_rem0 = 25'(r1_b) - 25'(r1_q0e) * 25'(stfs_bam_pkg::TableSpan);
    assign w_rem1 = r1_b - 24'(r1_q1e) * 24'(stfs_bam_pkg::Level1Span);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_b  <= r1_b;
            r2_q0 <= r1_q0e + 17'(w_rem0 >= 25'(stfs_bam_pkg::TableSpan));
            r2_q1 <= r1_q1e + 10'(w_rem1 >= 24'(stfs_bam_pkg::Level1Span));
        end
    end

    // stage 3: backing block and the two table blocks
    logic        w_kind;
    logic [7:0]  w_step0;
    logic [15:0] w_step1;
    logic [25:0] w_unit;
    logic [25:0] w_l1;
    logic [25:0] w_t;
    logic [25:0] w_backing;
    logic [25:0] w_lvl0;
    logic [25:0] w_lvl1;
    logic [19:0] r3_backing;
    logic [23:0] r3_level0;
    logic [23:0] r3_level1;
    logic        r3_err;

    assign w_kind  = i_cfg.package_kind;
    assign w_step0 = w_kind ? stfs_bam_pkg::Step0Double : stfs_bam_pkg::Step0Single;
    assign w_step1 = w_kind ? stfs_bam_pkg::Step1Double : stfs_bam_pkg::Step1Single;
    assign w_unit  = w_kind ? 26'd2 : 26'd1;
    assign w_l1    = (26'(r2_q1) + 26'd1) << w_kind;
    assign w_t     = ((26'(r2_q0) + 26'd1) << w_kind) + 26'(r2_b);

    assign w_backing = w_t + ((r2_q0 != 17'd0) ? w_l1 : 26'd0)
                           + ((r2_q1 != 10'd0) ? w_unit : 26'd0);
    assign w_lvl0 = 26'(r2_q0) * 26'(w_step0) + w_l1
                    + ((r2_q1 != 10'd0) ? w_unit : 26'd0);
    assign w_lvl1 = 26'(r2_q1) * 26'(w_step1) + w_unit;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_backing <= w_backing[19:0];
            r3_level0  <= (r2_q0 == 17'd0) ? 24'd0 : w_lvl0[23:0];
            r3_level1  <= (r2_q1 == 10'd0) ? 24'(w_step0) : w_lvl1[23:0];
            r3_err     <= (r2_b == stfs_bam_pkg::BlockLimit);
        end
    end

    // stage 4: byte address from the backing block
    logic [31:0] r4_data_address;
    logic [23:0] r4_level0;
    logic [23:0] r4_level1;
    logic        r4_err;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_data_address <= r3_err ? 32'd0
                               : {r3_backing, 12'd0} + i_cfg.first_table_address;
            r4_level0       <= r3_level0;
            r4_level1       <= r3_level1;
            r4_err          <= r3_err;
        end
    end

    assign o_data_address       = r4_data_address;
    assign o_level0_table_block = r4_level0;
    assign o_level1_table_block = r4_level1;
    assign o_block_error        = r4_err;

endmodule

// ===== sv/stfs_bam_skip.sv =====
module stfs_bam_skip (
    input  logic                   i_clk,
    input  stfs_bam_pkg::t_pipe_en i_en,
    input  stfs_bam_pkg::t_cfg     i_cfg,
    input  logic [31:0]            i_table_address,
    output logic [14:0]            o_skip_bytes
);

    logic        w_kind;
    logic [7:0]  w_step0;
    logic [15:0] w_step1;

    assign w_kind  = i_cfg.package_kind;
    assign w_step0 = w_kind ? stfs_bam_pkg::Step0Double : stfs_bam_pkg::Step0Single;
    assign w_step1 = w_kind ? stfs_bam_pkg::Step1Double : stfs_bam_pkg::Step1Single;

    // stage 1: table index relative to the first table
    logic [31:0] w_diff;
    logic [19:0] r1_t;

    assign w_diff = i_table_address - i_cfg.first_table_address;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_t <= w_diff[31:12];
        end
    end

    // stage 2: special indexes and fold past the level-1 table
    logic [20:0] w_sub;
    logic        w_above;
    logic [19:0] r2_tr;
    logic        r2_zero;
    logic        r2_hit;
    logic        r2_neg;

    assign w_sub   = 21'(r1_t) - 21'(w_step1) - (w_kind ? 21'd2 : 21'd1);
    assign w_above = (r1_t > 20'(w_step1));

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_tr   <= w_above ? w_sub[19:0] : r1_t;
            r2_zero <= (r1_t == 20'd0);
            r2_hit  <= (r1_t == 20'(w_step1));
            r2_neg  <= w_above && w_sub[20];
        end
    end

    // stage 3: quotient estimate by the level-1 step
    logic [17:0] w_recip;
    logic [37:0] w_prod;
    logic [19:0] r3_tr;
    logic [5:0]  r3_qe;
    logic        r3_zero;
    logic        r3_hit;
    logic        r3_neg;
    logic        r3_step0hit;

    assign w_recip = w_kind ? stfs_bam_pkg::RecipSkipDouble : stfs_bam_pkg::RecipSkipSingle;
    assign w_prod  = 38'(r2_tr) * 38'(w_recip);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_tr       <= r2_tr;
            r3_qe       <= w_prod[37:32];
            r3_zero     <= r2_zero;
            r3_hit      <= r2_hit;
            r3_neg      <= r2_neg;
            r3_step0hit <= (r2_tr == 20'(w_step0));
        end
    end

    // stage 4: divisibility and skip size
    logic [21:0] w_rem;
    logic        w_div;
    logic [1:0]  w_mult;
    logic [2:0]  w_scaled;
    logic [14:0] r4_skip;

    assign w_rem = 22'(r3_tr) - 22'(r3_qe) * 22'(w_step1);
    assign w_div = (w_rem == 22'd0) || (w_rem == 22'(w_step1));

    always_comb begin
        priority if (r3_zero) begin
            w_mult = stfs_bam_pkg::SkipOne;
        end else if (r3_hit) begin
            w_mult = stfs_bam_pkg::SkipThree;
        end else if (r3_neg) begin
            w_mult = stfs_bam_pkg::NegOneDivisible ? stfs_bam_pkg::SkipTwo
                                                   : stfs_bam_pkg::SkipOne;
        end else if (r3_step0hit || w_div) begin
            w_mult = stfs_bam_pkg::SkipTwo;
        end else begin
            w_mult = stfs_bam_pkg::SkipOne;
        end
    end

    assign w_scaled = w_kind ? {w_mult, 1'b0} : {1'b0, w_mult};

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_skip <= {w_scaled, 12'd0};
        end
    end

    assign o_skip_bytes = r4_skip;

endmodule
